@@ rtl/core/ppd_pkg.sv @@
// Package for the prefix period detector: widths, constants, state enums.
// Used by every module under rtl/core except ppd_ram.
package ppd_pkg;
   localparam int MaxLenDefault = 4096;
   localparam int FieldW = 13;
   localparam int SymW = 8;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_CMP, BK_DIV, BK_OUT
   } bk_state_type;

   typedef struct packed {
      logic [SymW-1:0] symbol;
      logic            first;
   } fr_word_type;
endpackage

@@ rtl/core/prefix_period_detector_core.sv @@
// Prefix period detector: each byte extends the KMP failure function of the stored
// prefix; a serial divide decides if the prefix is whole repeats of a block. In the
// back end a byte walks the failure links through the two stores (READ then CMP for
// each step, amortized under one step per byte), then runs the bit-serial divider in
// DIV and leaves through OUT. The divide is skipped when the failure value is zero,
// the first byte of a string skips the walk, and an overflow byte goes from IDLE
// straight to DIV and OUT. Bytes beyond MAX_LEN are flagged overflow.
// Depends on ppd_pkg.
module prefix_period_detector_core #(
   parameter int MaxLen = ppd_pkg::MaxLenDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ppd_pkg::SymW-1:0]   req_symbol,
   input  logic                       req_first,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ppd_pkg::FieldW-1:0] rsp_prefix_length,
   output logic                       rsp_periodic,
   output logic [ppd_pkg::FieldW-1:0] rsp_repeats,
   output logic [ppd_pkg::FieldW-1:0] rsp_period,
   output logic                       rsp_overflow
);
   import ppd_pkg::*;
   fr_word_type in_word, q_word;
   logic q_valid, q_ready;

   assign in_word.symbol = req_symbol;
   assign in_word.first = req_first;

   ppd_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_word(in_word), .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word));

   ppd_back #(.MaxLen(MaxLen)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_ready(q_ready),
      .in_word(q_word), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prefix_length(rsp_prefix_length), .rsp_periodic(rsp_periodic),
      .rsp_repeats(rsp_repeats), .rsp_period(rsp_period), .rsp_overflow(rsp_overflow));

   a_per_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_periodic |-> rsp_repeats == '0 && rsp_period == '0)
      else $error("non-periodic word carries repeats or period");
   a_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_periodic)
      else $error("overflow word marked periodic");
   a_per_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_periodic |-> rsp_repeats > 13'd1 && rsp_period != '0)
      else $error("periodic word with bad repeat count");
endmodule

@@ rtl/core/ppd_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ppd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/ppd_front.sv @@
// Front end: two-entry input queue that decouples acceptance from the back end.
// Depends on ppd_pkg.
module ppd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ppd_pkg::fr_word_type in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output ppd_pkg::fr_word_type out_word
);
   import ppd_pkg::*;
   fr_word_type q_ff [2];
   logic        rd_ff, wr_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_word  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_word;
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

@@ rtl/core/ppd_back.sv @@
// Back end: failure-function walk over the stores, then serial divisibility test.
// Depends on ppd_pkg and ppd_ram.
module ppd_back #(
   parameter int MaxLen = ppd_pkg::MaxLenDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ppd_pkg::fr_word_type       in_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ppd_pkg::FieldW-1:0] rsp_prefix_length,
   output logic                       rsp_periodic,
   output logic [ppd_pkg::FieldW-1:0] rsp_repeats,
   output logic [ppd_pkg::FieldW-1:0] rsp_period,
   output logic                       rsp_overflow
);
   import ppd_pkg::*;
   localparam int AW = $clog2(MaxLen + 1);   // holds count up to MaxLen
   localparam int PW = $clog2(MaxLen);

   bk_state_type st_ff, st_in;
   logic [AW-1:0] cnt_ff, cnt_in, j_ff, j_in, m_ff, m_in;
   logic [SymW-1:0] c_ff, c_in;
   // divider: remainder, quotient, divisor, dividend, bit counter
   logic [AW-1:0] rem_ff, rem_in, quo_ff, quo_in, per_ff, per_in, num_ff, num_in;
   logic [$clog2(AW+1)-1:0] bit_ff, bit_in;
   logic ov_ff, ov_in;

   // output register
   logic vld_ff, vld_in, pd_ff, pd_in, ovo_ff, ovo_in;
   logic [FieldW-1:0] len_ff, len_in, rep_ff, rep_in, pr_ff, pr_in;

   logic          pwe, fwe;
   logic [PW-1:0] pwa, pra;
   logic [AW-1:0] fwa, fra, frd;
   logic [SymW-1:0] prd;
   logic [AW:0]   trial;

   ppd_ram #(.Width(SymW), .Depth(MaxLen)) u_pat (
      .clock(clock), .wr_en(pwe), .wr_addr(pwa), .wr_data(c_ff),
      .rd_addr(pra), .rd_data(prd));
   ppd_ram #(.Width(AW), .Depth(MaxLen + 1)) u_fail (
      .clock(clock), .wr_en(fwe), .wr_addr(fwa), .wr_data(j_in),
      .rd_addr(fra), .rd_data(frd));

   assign rsp_valid = vld_ff;
   assign rsp_prefix_length = len_ff;
   assign rsp_periodic = pd_ff;
   assign rsp_repeats = rep_ff;
   assign rsp_period = pr_ff;
   assign rsp_overflow = ovo_ff;
   assign trial = {rem_ff, num_ff[AW-1]} - {1'b0, per_ff};

   always_ff @(posedge clock) begin
      c_ff <= c_in; j_ff <= j_in; rem_ff <= rem_in; quo_ff <= quo_in;
      per_ff <= per_in; num_ff <= num_in; bit_ff <= bit_in; ov_ff <= ov_in;
      pd_ff <= pd_in; ovo_ff <= ovo_in; len_ff <= len_in; rep_ff <= rep_in;
      pr_ff <= pr_in;
      if (reset) begin
         st_ff <= BK_IDLE;
         cnt_ff <= '0;
         m_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         m_ff <= m_in;
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; m_in = m_ff; j_in = j_ff; c_in = c_ff;
      rem_in = rem_ff; quo_in = quo_ff; per_in = per_ff; num_in = num_ff;
      bit_in = bit_ff; ov_in = ov_ff;
      vld_in = vld_ff && !rsp_ready;
      pd_in = pd_ff; ovo_in = ovo_ff; len_in = len_ff; rep_in = rep_ff; pr_in = pr_ff;
      in_ready = 1'b0;
      pwe = 1'b0; pwa = cnt_ff[PW-1:0];
      fwe = 1'b0; fwa = cnt_ff;
      pra = j_ff[PW-1:0]; fra = j_ff;
      case (st_ff)
         BK_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               c_in = in_word.symbol;
               if (in_word.first) begin
                  cnt_in = '0; m_in = '0;
               end
               j_in = in_word.first ? '0 : m_ff;
               ov_in = !in_word.first && (cnt_ff == AW'(MaxLen));
               st_in = BK_READ;
               if (in_word.first || cnt_ff == '0) begin
                  // lone byte: failure 0, skip the walk
                  j_in = '0;
                  st_in = BK_CMP;
               end
               if (ov_in) st_in = BK_DIV;
            end
         end
         BK_READ: begin
            // fetch pattern[j] and failure[j]
            st_in = BK_CMP;
         end
         BK_CMP: begin
            if (cnt_ff == '0) begin
               j_in = '0;
               st_in = BK_DIV;
            end else if (prd == c_ff) begin
               j_in = j_ff + 1'b1;
               st_in = BK_DIV;
            end else if (j_ff == '0) begin
               st_in = BK_DIV;
            end else begin
               j_in = frd;
               st_in = BK_READ;
            end
            if (st_in == BK_DIV) begin
               // commit byte and failure value, set up the divide len / (len-j)
               pwe = 1'b1;
               fwe = 1'b1;
               fwa = cnt_ff + 1'b1;
               m_in = j_in;
               cnt_in = cnt_ff + 1'b1;
               per_in = cnt_ff + 1'b1 - j_in;
               num_in = cnt_ff + 1'b1;
               rem_in = '0; quo_in = '0;
               bit_in = ($clog2(AW+1))'(AW);
               if (j_in == '0) bit_in = '0;
            end
         end
         BK_DIV: begin
            if (bit_ff != '0 && !ov_ff) begin
               if (!trial[AW]) begin
                  rem_in = trial[AW-1:0];
                  quo_in = {quo_ff[AW-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[AW-2:0], num_ff[AW-1]};
                  quo_in = {quo_ff[AW-2:0], 1'b0};
               end
               num_in = {num_ff[AW-2:0], 1'b0};
               bit_in = bit_ff - 1'b1;
            end else begin
               st_in = BK_OUT;
            end
         end
         BK_OUT: begin
            // hold until the output register is free
            if (!vld_ff || rsp_ready) begin
               vld_in = 1'b1;
               ovo_in = ov_ff;
               if (ov_ff) begin
                  len_in = FieldW'(MaxLen);
                  pd_in = 1'b0; rep_in = '0; pr_in = '0;
               end else begin
                  len_in = FieldW'(cnt_ff);
                  pd_in = (m_ff != '0) && (rem_ff == '0);
                  rep_in = pd_in ? FieldW'(quo_ff) : '0;
                  pr_in = pd_in ? FieldW'(per_ff) : '0;
               end
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end
endmodule
